### hdl/dod_pkg.sv
// Shared types, constants and calendar helpers for the date offset block.
// Used by dod_ctrl, dod_dpath and date_offset_days; depends on nothing.
package dod_pkg;

    localparam int YEAR_W  = 12;
    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int CNT_W   = 16;
    localparam int REM_W   = 7;   // year mod 100
    localparam int ACC_W   = 18;  // signed running day count

    localparam logic [YEAR_W-1:0] YEAR_MAX     = 12'd4095;
    localparam logic [YEAR_W-1:0] CENTURY      = 12'd100;
    localparam logic [REM_W-1:0]  REM_LAST     = 7'd99;
    localparam logic [REM_W-1:0]  REM_OF_MAX   = 7'd95;  // 4095 mod 100
    localparam logic [1:0]        CENT_OF_MAX  = 2'd0;   // (4095 / 100) mod 4

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_31 = 5'd31;
    localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0] LEN_28 = 5'd28;

    typedef struct packed {
        logic              func;
        logic [DAY_W-1:0]  day_in;
        logic [MON_W-1:0]  month_in;
        logic [YEAR_W-1:0] year_in;
        logic [CNT_W-1:0]  offset;
    } item_t;

    typedef struct packed {
        logic [DAY_W-1:0]  day_out;
        logic [MON_W-1:0]  month_out;
        logic [YEAR_W-1:0] year_out;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SETTLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic reduce;
        logic settle;
        logic step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic reduce_done;
        logic walk_done;
    } status_t;

    // rem = year mod 100, cent = (year / 100) mod 4
    function automatic logic leap_year(input logic [REM_W-1:0] rem, input logic [1:0] cent);
        logic by4;
        by4 = (rem[1:0] == 2'd0);
        return (by4 && (rem != '0)) || ((rem == '0) && (cent == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MON_W-1:0] mon,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        if ((mon == MON_APR) || (mon == MON_JUN) || (mon == MON_SEP) || (mon == MON_NOV))
            len = LEN_30;
        else if (mon == MON_FEB)
            len = leap ? LEN_29 : LEN_28;
        else
            len = LEN_31;
        return len;
    endfunction

endpackage

### hdl/dod_ctrl.sv
// Sequencer for the date offset block: reduce year, settle date, walk months.
// Depends on dod_pkg; drives dod_dpath through cmd_t, reads status_t.
module dod_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  dod_pkg::status_t status,
    output dod_pkg::cmd_t    cmd
);

    dod_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dod_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dod_pkg::ST_IDLE:
                if (item_valid)
                    state_next = dod_pkg::ST_REDUCE;
            dod_pkg::ST_REDUCE:
                if (status.reduce_done)
                    state_next = dod_pkg::ST_SETTLE;
            dod_pkg::ST_SETTLE:
                state_next = dod_pkg::ST_WALK;
            dod_pkg::ST_WALK:
                if (status.walk_done)
                    state_next = slot_free ? dod_pkg::ST_IDLE : dod_pkg::ST_FINISH;
            dod_pkg::ST_FINISH:
                if (slot_free)
                    state_next = dod_pkg::ST_IDLE;
            default:
                state_next = dod_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            dod_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            dod_pkg::ST_REDUCE:
                cmd.reduce = !status.reduce_done;
            dod_pkg::ST_SETTLE:
                cmd.settle = 1'b1;
            dod_pkg::ST_WALK:
            begin
                cmd.step    = !status.walk_done;
                cmd.capture = status.walk_done && slot_free;
            end
            dod_pkg::ST_FINISH:
                cmd.capture = slot_free;
            default:
                cmd = '0;
        endcase
    end

    // result register is freed by a transfer and refilled by a capture
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    assign result_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || result_ready))
        else $error("result overwritten before transfer");

    a_capture_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> result_valid)
        else $error("capture did not raise result_valid");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.reduce, cmd.settle, cmd.step, cmd.capture}))
        else $error("conflicting datapath commands");

endmodule

### hdl/dod_dpath.sv
// Datapath for the date offset block: year residues, month walk, result register.
// Depends on dod_pkg; controlled by dod_ctrl through cmd_t and status_t.
module dod_dpath (
    input  logic             clk,
    input  logic             rst_n,
    input  dod_pkg::cmd_t    cmd,
    input  dod_pkg::item_t   item,
    output dod_pkg::status_t status,
    output dod_pkg::result_t result
);

    logic                               sub_reg;
    logic [dod_pkg::DAY_W-1:0]          day_reg;
    logic [dod_pkg::MON_W-1:0]          mon_reg, mon_next;
    logic [dod_pkg::YEAR_W-1:0]         yr_reg, yr_next;
    logic [dod_pkg::CNT_W-1:0]          cnt_reg;
    logic [dod_pkg::YEAR_W-1:0]         rem_reg, rem_next;
    logic [1:0]                         cent_reg, cent_next;
    logic signed [dod_pkg::ACC_W-1:0]   acc_reg, acc_next;
    dod_pkg::result_t                   res_reg;

    logic [dod_pkg::REM_W-1:0] rem7;
    logic                      leap;
    logic [dod_pkg::DAY_W-1:0] len_cur, len_prev, day_fix;
    logic [dod_pkg::MON_W-1:0] mon_clamp, mon_dec;
    logic signed [dod_pkg::ACC_W-1:0] len_cur_s, len_prev_s, day_s, cnt_s;

    assign rem7      = rem_reg[dod_pkg::REM_W-1:0];
    assign leap      = dod_pkg::leap_year(rem7, cent_reg);
    assign len_cur   = dod_pkg::month_length(mon_reg, leap);
    assign mon_dec   = mon_reg - dod_pkg::MON_W'(1);
    // the previous month never wraps onto February, so this year's leap flag serves
    assign len_prev  = dod_pkg::month_length(mon_dec, leap);
    assign len_cur_s  = $signed({{(dod_pkg::ACC_W-dod_pkg::DAY_W){1'b0}}, len_cur});
    assign len_prev_s = $signed({{(dod_pkg::ACC_W-dod_pkg::DAY_W){1'b0}}, len_prev});

    always_comb
    begin
        if (item.month_in < dod_pkg::MON_JAN)
            mon_clamp = dod_pkg::MON_JAN;
        else if (item.month_in > dod_pkg::MON_DEC)
            mon_clamp = dod_pkg::MON_DEC;
        else
            mon_clamp = item.month_in;
    end

    always_comb
    begin
        if (day_reg == '0)
            day_fix = dod_pkg::DAY_W'(1);
        else if (day_reg > len_cur)
            day_fix = len_cur;
        else
            day_fix = day_reg;
    end

    assign day_s = $signed({{(dod_pkg::ACC_W-dod_pkg::DAY_W){1'b0}}, day_fix});
    assign cnt_s = $signed({{(dod_pkg::ACC_W-dod_pkg::CNT_W){1'b0}}, cnt_reg});

    assign status.reduce_done = (rem_reg < dod_pkg::CENTURY);
    assign status.walk_done   = sub_reg ? (acc_reg > 0) : (acc_reg <= len_cur_s);

    always_comb
    begin
        mon_next  = mon_reg;
        yr_next   = yr_reg;
        rem_next  = rem_reg;
        cent_next = cent_reg;
        acc_next  = acc_reg;
        priority if (cmd.load)
        begin
            mon_next  = mon_clamp;
            yr_next   = item.year_in;
            rem_next  = item.year_in;
            cent_next = 2'd0;
        end
        else if (cmd.reduce)
        begin
            rem_next  = rem_reg - dod_pkg::CENTURY;
            cent_next = cent_reg + 2'd1;
        end
        else if (cmd.settle)
        begin
            acc_next = sub_reg ? (day_s - cnt_s) : (day_s + cnt_s);
        end
        else if (cmd.step)
        begin
            if (!sub_reg)
            begin
                acc_next = acc_reg - len_cur_s;
                if (mon_reg == dod_pkg::MON_DEC)
                begin
                    mon_next = dod_pkg::MON_JAN;
                    if (yr_reg == dod_pkg::YEAR_MAX)
                    begin
                        yr_next   = '0;
                        rem_next  = '0;
                        cent_next = 2'd0;
                    end
                    else
                    begin
                        yr_next = yr_reg + dod_pkg::YEAR_W'(1);
                        if (rem7 == dod_pkg::REM_LAST)
                        begin
                            rem_next  = '0;
                            cent_next = cent_reg + 2'd1;
                        end
                        else
                            rem_next = rem_reg + dod_pkg::YEAR_W'(1);
                    end
                end
                else
                    mon_next = mon_reg + dod_pkg::MON_W'(1);
            end
            else
            begin
                if (mon_reg == dod_pkg::MON_JAN)
                begin
                    mon_next = dod_pkg::MON_DEC;
                    acc_next = acc_reg + dod_pkg::ACC_W'(dod_pkg::LEN_31);
                    if (yr_reg == '0)
                    begin
                        yr_next   = dod_pkg::YEAR_MAX;
                        rem_next  = dod_pkg::YEAR_W'(dod_pkg::REM_OF_MAX);
                        cent_next = dod_pkg::CENT_OF_MAX;
                    end
                    else
                    begin
                        yr_next = yr_reg - dod_pkg::YEAR_W'(1);
                        if (rem7 == '0)
                        begin
                            rem_next  = dod_pkg::YEAR_W'(dod_pkg::REM_LAST);
                            cent_next = cent_reg - 2'd1;
                        end
                        else
                            rem_next = rem_reg - dod_pkg::YEAR_W'(1);
                    end
                end
                else
                begin
                    mon_next = mon_dec;
                    acc_next = acc_reg + len_prev_s;
                end
            end
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sub_reg <= item.func;
            day_reg <= item.day_in;
            cnt_reg <= item.offset;
        end
        mon_reg  <= mon_next;
        yr_reg   <= yr_next;
        rem_reg  <= rem_next;
        cent_reg <= cent_next;
        acc_reg  <= acc_next;
        if (cmd.capture)
        begin
            res_reg.day_out   <= acc_reg[dod_pkg::DAY_W-1:0];
            res_reg.month_out <= mon_reg;
            res_reg.year_out  <= yr_reg;
        end
    end

    assign result = res_reg;

    a_step_residue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (rem_reg < dod_pkg::CENTURY))
        else $error("month walk with unreduced year residue");

    a_step_month: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((mon_reg >= dod_pkg::MON_JAN) && (mon_reg <= dod_pkg::MON_DEC)))
        else $error("month out of range during walk");

    a_capture_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (status.walk_done && (acc_reg > 0)))
        else $error("capture before walk finished");

endmodule

### hdl/date_offset_days.sv
// Top level of the Gregorian date offset block.
// Depends on dod_pkg, dod_ctrl and dod_dpath.
//
// Adds (func 0) or subtracts (func 1) offset days to a date, one result per item.
// An item is taken only when the block is idle; its work runs in three phases:
// reducing the year to its residue mod 100 (one subtract of 100 per cycle),
// settling the start date (month clamped to 1..12 on load, day to 1..length),
// then walking the months, stepping one month per cycle. The result sits in an
// output register, so the next item is taken while the previous result still
// waits for its transfer. Years wrap modulo 4096.
module date_offset_days (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  dod_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output dod_pkg::result_t result
);

    dod_pkg::cmd_t    cmd;
    dod_pkg::status_t status;

    dod_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    dod_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .status (status),
        .result (result)
    );

endmodule

### bench/testbench.sv
// Self-checking bench for date_offset_days: adds/subtracts day counts on Gregorian dates.
// Depends on dod_pkg and the date_offset_days RTL; drives valid/ready on both sides.
`timescale 1ns / 1ps

module testbench;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;
    localparam int   ITEMS_PER_PHASE = 75;
    localparam int   DRAIN_CYCLES    = 2500;
    localparam int   MAX_REPORTS     = 10;

    typedef struct {
        dod_pkg::item_t   it;
        bit               known;
        dod_pkg::result_t want;
    } date_case_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    dod_pkg::item_t   item_bus;
    logic             result_valid;
    logic             result_ready = 1'b0;
    dod_pkg::result_t result_bus;

    int tx_idle_pct = 14;
    int rx_idle_pct = 84;
    int mismatch_count = 0;

    dod_pkg::result_t pending_dates[$];
    date_case_t       directed_cases[$];

    date_offset_days i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in(input int m, input int y);
        int len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = is_leap(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // Walks month by month; out-of-range month/day are clamped first, years wrap at 4096.
    function automatic dod_pkg::result_t shift_date(input dod_pkg::item_t it);
        int               mon;
        int               yr;
        int               len;
        int               acc;
        dod_pkg::result_t r;
        mon = int'(it.month_in);
        yr  = int'(it.year_in);
        if (mon < 1)
            mon = 1;
        if (mon > 12)
            mon = 12;
        len = days_in(mon, yr);
        acc = int'(it.day_in);
        if (acc < 1)
            acc = 1;
        if (acc > len)
            acc = len;
        if (it.func == OP_ADD)
        begin
            acc = acc + int'(it.offset);
            while (acc > len)
            begin
                acc = acc - len;
                mon = mon + 1;
                if (mon > 12)
                begin
                    mon = 1;
                    yr  = (yr + 1) % 4096;
                end
                len = days_in(mon, yr);
            end
        end
        else
        begin
            acc = acc - int'(it.offset);
            while (acc <= 0)
            begin
                mon = mon - 1;
                if (mon == 0)
                begin
                    mon = 12;
                    yr  = (yr + 4095) % 4096;
                end
                acc = acc + days_in(mon, yr);
            end
        end
        r.day_out   = acc[dod_pkg::DAY_W-1:0];
        r.month_out = mon[dod_pkg::MON_W-1:0];
        r.year_out  = yr[dod_pkg::YEAR_W-1:0];
        return r;
    endfunction

    function automatic dod_pkg::item_t make_item(input logic f, input int d, input int m,
                                                 input int y, input int off);
        dod_pkg::item_t it;
        it.func     = f;
        it.day_in   = d[dod_pkg::DAY_W-1:0];
        it.month_in = m[dod_pkg::MON_W-1:0];
        it.year_in  = y[dod_pkg::YEAR_W-1:0];
        it.offset   = off[dod_pkg::CNT_W-1:0];
        return it;
    endfunction

    // known = 1: the expected date is typed in; otherwise the predictor supplies it
    task automatic add_case(input logic f, input int d, input int m, input int y,
                            input int off, input bit known,
                            input int wd, input int wm, input int wy);
        date_case_t c;
        c.it              = make_item(f, d, m, y, off);
        c.known           = known;
        c.want.day_out    = wd[dod_pkg::DAY_W-1:0];
        c.want.month_out  = wm[dod_pkg::MON_W-1:0];
        c.want.year_out   = wy[dod_pkg::YEAR_W-1:0];
        directed_cases.push_back(c);
    endtask

    function automatic dod_pkg::item_t draw_date_item();
        dod_pkg::item_t it;
        logic [63:0]    noise;
        int             kind;
        int             y;
        int             m;
        int             off;
        int             span;
        kind = $urandom_range(99);
        span = $urandom_range(99);
        if (span < 55)
            off = $urandom_range(400);
        else if (span < 80)
            off = $urandom_range(4000);
        else
            off = $urandom_range(65535);
        if (kind < 15)
        begin
            // raw noise: any bit pattern in every field
            noise = {$urandom, $urandom};
            it    = noise[$bits(dod_pkg::item_t)-1:0];
        end
        else
        begin
            if (kind < 30)
                y = ($urandom_range(1) != 0) ? $urandom_range(3) : $urandom_range(4095, 4092);
            else
                y = $urandom_range(2200, 1900);
            m  = $urandom_range(12, 1);
            it = make_item(logic'($urandom_range(1)), $urandom_range(days_in(m, y), 1),
                           m, y, off);
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_item(input dod_pkg::item_t it, input dod_pkg::result_t want);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_dates.push_back(want);
        @(negedge clk);
    endtask

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin : check_result
        dod_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transfer: %0d/%0d/%0d", result_bus.day_out,
                             result_bus.month_out, result_bus.year_out);
            end
            else
            begin
                want = pending_dates.pop_front();
                if ((result_bus.day_out !== want.day_out) ||
                    (result_bus.month_out !== want.month_out) ||
                    (result_bus.year_out !== want.year_out))
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("date mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.day_out, want.month_out, want.year_out,
                                 result_bus.day_out, result_bus.month_out,
                                 result_bus.year_out);
                end
            end
        end
    end

    initial
    begin : stimulus
        dod_pkg::item_t it;
        int             ph;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item_bus   = '0;

        // zero offsets and clamping
        add_case(OP_ADD, 15, 6, 2024, 0, 1, 15, 6, 2024);
        add_case(OP_SUB, 15, 6, 2024, 0, 1, 15, 6, 2024);
        add_case(OP_ADD, 0, 0, 1999, 0, 1, 1, dod_pkg::MON_JAN, 1999);
        add_case(OP_SUB, 0, 0, 0, 0, 1, 1, dod_pkg::MON_JAN, 0);
        add_case(OP_ADD, 31, 15, 2001, 0, 1, 31, dod_pkg::MON_DEC, 2001);
        add_case(OP_ADD, 31, 13, 0, 0, 1, 31, dod_pkg::MON_DEC, 0);
        add_case(OP_ADD, 31, dod_pkg::MON_FEB, 1900, 0, 1, 28, dod_pkg::MON_FEB, 1900);
        add_case(OP_ADD, 30, dod_pkg::MON_FEB, 2000, 0, 1, 29, dod_pkg::MON_FEB, 2000);
        add_case(OP_ADD, 29, dod_pkg::MON_FEB, 2100, 0, 1, 28, dod_pkg::MON_FEB, 2100);
        add_case(OP_ADD, 31, dod_pkg::MON_APR, 2100, 0, 1, 30, dod_pkg::MON_APR, 2100);
        // leap rule and month boundaries
        add_case(OP_ADD, 28, dod_pkg::MON_FEB, 2000, 1, 1, 29, dod_pkg::MON_FEB, 2000);
        add_case(OP_ADD, 28, dod_pkg::MON_FEB, 1900, 1, 1, 1, 3, 1900);
        add_case(OP_SUB, 1, 3, 2400, 1, 1, 29, dod_pkg::MON_FEB, 2400);
        add_case(OP_SUB, 1, 3, 2023, 1, 1, 28, dod_pkg::MON_FEB, 2023);
        add_case(OP_ADD, 31, dod_pkg::MON_JAN, 2023, 1, 1, 1, dod_pkg::MON_FEB, 2023);
        add_case(OP_ADD, 31, 10, 2023, 31, 1, 1, dod_pkg::MON_DEC, 2023);
        // year wrap through twelve bits
        add_case(OP_ADD, 31, dod_pkg::MON_DEC, 4095, 1, 1, 1, dod_pkg::MON_JAN, 0);
        add_case(OP_SUB, 1, dod_pkg::MON_JAN, 0, 1, 1, 31, dod_pkg::MON_DEC, 4095);
        add_case(OP_ADD, 1, dod_pkg::MON_JAN, 4095, 65535, 0, 0, 0, 0);
        // full-range offsets
        add_case(OP_ADD, 1, dod_pkg::MON_JAN, 1900, 65535, 0, 0, 0, 0);
        add_case(OP_SUB, 31, dod_pkg::MON_DEC, 2200, 65535, 0, 0, 0, 0);
        add_case(OP_SUB, 1, dod_pkg::MON_JAN, 1900, 65535, 0, 0, 0, 0);
        add_case(OP_ADD, 31, dod_pkg::MON_DEC, 2200, 65535, 0, 0, 0, 0);
        add_case(OP_ADD, 0, 0, 4095, 65535, 0, 0, 0, 0);
        add_case(OP_SUB, 31, 15, 4095, 65535, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_cases[k])
            push_item(directed_cases[k].it,
                      directed_cases[k].known ? directed_cases[k].want
                                              : shift_date(directed_cases[k].it));

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 84;
                end
                1:
                begin
                    tx_idle_pct = 84;
                    rx_idle_pct = 14;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                it = draw_date_item();
                push_item(it, shift_date(it));
            end
        end
        item_valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
